### rtl/core/idsc_pkg.sv
`default_nettype none
package idsc_pkg;

	// Geometry and field widths of the block.
	localparam int unsigned MaxWidth    = 4096;
	localparam int unsigned NumChannels = 4;
	localparam int unsigned ChanW       = 8;
	localparam int unsigned DeltaW      = 8;
	localparam int unsigned CoordW      = 12;
	localparam int unsigned CountW      = 25;
	localparam int unsigned WidthW      = 13;
	localparam int unsigned ThreshW     = 8;
	localparam int unsigned FatalW      = 9;
	localparam int unsigned CfgDataW    = 25;
	localparam int unsigned CfgIndexW   = 2;
	localparam int unsigned InDataW     = 2 * NumChannels * ChanW;
	localparam int unsigned OutDataW    = 64;

	localparam logic [WidthW-1:0] WidthMax   = WidthW'(MaxWidth);
	localparam logic [WidthW-1:0] WidthOne   = WidthW'(1);
	localparam logic [CountW-1:0] CountMax   = {CountW{1'b1}};

	// Register map of the configuration port.
	typedef enum logic [CfgIndexW-1:0] {
		REG_IMAGE_WIDTH     = 2'd0,
		REG_PIXEL_THRESHOLD = 2'd1,
		REG_FATAL_THRESHOLD = 2'd2,
		REG_ALLOWED_COUNT   = 2'd3
	} reg_index_t;

	// Register values as seen by the front and back parts.
	typedef struct packed {
		logic [WidthW-1:0]  image_width;
		logic [ThreshW-1:0] pixel_threshold;
		logic [FatalW-1:0]  fatal_threshold;
		logic [CountW-1:0]  allowed_count;
	} cfg_t;

	// One classified pixel as it travels from front to back.
	typedef struct packed {
		logic [DeltaW-1:0] delta;
		logic              over;
		logic              last;
	} item_t;

	// One result of an image.
	typedef struct packed {
		logic              verdict;
		logic [CountW-1:0] differing_total;
		logic [CoordW-1:0] worst_row;
		logic [CoordW-1:0] worst_col;
		logic [DeltaW-1:0] worst_delta;
	} result_t;

	function automatic logic [ChanW-1:0] abs_gap(input logic [ChanW-1:0] a,
			input logic [ChanW-1:0] b);
		abs_gap = (a > b) ? (a - b) : (b - a);
	endfunction

endpackage
`default_nettype wire

### rtl/core/image_difference_statistics_core.sv
`default_nettype none
// Channel   Direction  Handshake                      Contents
// s_axis    in         s_axis_tvalid / s_axis_tready  one reference/candidate pixel pair
// m_axis    out        m_axis_tvalid / m_axis_tready  one result per image
// cfg       in         cfg_we (no wait)               register writes by index
//
// Throughput is one pixel request per cycle unless the input stalls. When
// nothing stalls, the result of an image passes the classify register and the
// queue after its last pixel request is taken, then the output register loads
// it. Reset clears counters, running statistics and valid flags at once, with
// no clearing pass; data registers are not reset. The input stalls only when
// the four-entry queue backs up, which happens only while a finished result
// waits on m_axis_tready and the next image end has reached the head of the queue.
module image_difference_statistics_core import idsc_pkg::*; (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   s_axis_tvalid,
	output logic                  s_axis_tready,
	// Fields from bit 0 up: ref_red, ref_green, ref_blue, ref_alpha,
	// cand_red, cand_green, cand_blue, cand_alpha.
	input  wire [InDataW-1:0]     s_axis_tdata,
	// last_pixel: marks the final pixel of an image.
	input  wire                   s_axis_tlast,
	output logic                  m_axis_tvalid,
	input  wire                   m_axis_tready,
	// Fields from bit 0 up: worst_delta, worst_col, worst_row, differing_total,
	// verdict, then zero fill.
	output logic [OutDataW-1:0]   m_axis_tdata,
	input  wire                   cfg_we,
	input  wire [CfgIndexW-1:0]   cfg_index,
	input  wire [CfgDataW-1:0]    cfg_data
);

	cfg_t    cfg_q;
	logic    push;
	item_t   push_item;
	logic    q_ready;
	logic    q_valid;
	item_t   q_item;
	logic    pop;
	result_t result;

	// Configuration registers. They keep their values across images; the user must
	// write them only while the block is idle, as the block does not enforce it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.image_width     <= WidthOne;
			cfg_q.pixel_threshold <= '0;
			cfg_q.fatal_threshold <= FatalW'(256);
			cfg_q.allowed_count   <= '0;
		end else if (cfg_we) begin
			unique case (reg_index_t'(cfg_index))
				REG_IMAGE_WIDTH:     cfg_q.image_width     <= cfg_data[WidthW-1:0];
				REG_PIXEL_THRESHOLD: cfg_q.pixel_threshold <= cfg_data[ThreshW-1:0];
				REG_FATAL_THRESHOLD: cfg_q.fatal_threshold <= cfg_data[FatalW-1:0];
				REG_ALLOWED_COUNT:   cfg_q.allowed_count   <= cfg_data[CountW-1:0];
				default:             cfg_q                 <= cfg_q;
			endcase
		end
	end

	// The front part computes the pixel difference and whether it counts as
	// differing, then hands the classified pixel to the queue.
	idsc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_data   (s_axis_tdata),
		.in_last   (s_axis_tlast),
		.push      (push),
		.push_item (push_item),
		.q_ready   (q_ready)
	);

	idsc_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.ready     (q_ready),
		.pop       (pop),
		.valid     (q_valid),
		.pop_item  (q_item)
	);

	// The back part tracks position, worst difference and count, and loads
	// the output register at the end of each image.
	idsc_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.q_valid    (q_valid),
		.q_item     (q_item),
		.pop        (pop),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_result (result)
	);

	assign m_axis_tdata = OutDataW'(result);

endmodule
`default_nettype wire

### rtl/core/idsc_front.sv
`default_nettype none
module idsc_front import idsc_pkg::*; (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire cfg_t           cfg,
	input  wire                 in_valid,
	output logic                in_ready,
	input  wire [InDataW-1:0]   in_data,
	input  wire                 in_last,
	output logic                push,
	output item_t               push_item,
	input  wire                 q_ready
);

	logic              valid_s1;
	item_t             item_s1;
	logic [DeltaW-1:0] delta;

	// Largest absolute difference over the channels; reference channels sit
	// in the low half of the data word, candidate channels in the high half.
	always_comb begin
		logic [ChanW-1:0] g;
		delta = '0;
		for (int c = 0; c < NumChannels; c++) begin
			g = abs_gap(in_data[c*ChanW +: ChanW],
				in_data[(c+NumChannels)*ChanW +: ChanW]);
			if (g > delta) begin
				delta = g;
			end
		end
	end

	assign in_ready  = !valid_s1 || q_ready;
	assign push      = valid_s1 && q_ready;
	assign push_item = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (q_ready) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1.delta <= delta;
			item_s1.over  <= (delta > cfg.pixel_threshold);
			item_s1.last  <= in_last;
		end
	end

endmodule
`default_nettype wire

### rtl/core/idsc_queue.sv
`default_nettype none
module idsc_queue import idsc_pkg::*; (
	input  wire   clk,
	input  wire   arst_n,
	input  wire   push,
	input  item_t push_item,
	output logic  ready,
	input  wire   pop,
	output logic  valid,
	output item_t pop_item
);

	localparam int unsigned Depth = 4;
	localparam int unsigned PtrW  = $clog2(Depth);

	item_t             mem [Depth];
	logic [PtrW-1:0]   wr_ptr_q;
	logic [PtrW-1:0]   rd_ptr_q;
	logic [PtrW:0]     count_q;

	assign ready    = (count_q != (PtrW+1)'(Depth));
	assign valid    = (count_q != '0);
	assign pop_item = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (PtrW+1)'(Depth))
		else $error("queue holds more entries than its depth");

	a_push_only_grows: assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |=> count_q == $past(count_q) + 1'b1)
		else $error("queue count did not follow a lone push");

endmodule
`default_nettype wire

### rtl/core/idsc_back.sv
`default_nettype none
module idsc_back import idsc_pkg::*; (
	input  wire     clk,
	input  wire     arst_n,
	input  wire cfg_t cfg,
	input  wire     q_valid,
	input  item_t   q_item,
	output logic    pop,
	output logic    out_valid,
	input  wire     out_ready,
	output result_t out_result
);

	logic [CoordW-1:0] col_q;
	logic [CoordW-1:0] row_q;
	logic [DeltaW-1:0] worst_q;
	logic [CoordW-1:0] worst_col_q;
	logic [CoordW-1:0] worst_row_q;
	logic [CountW-1:0] count_q;
	logic              out_valid_q;
	result_t           out_q;

	logic [DeltaW-1:0] worst_nx;
	logic [CoordW-1:0] worst_col_nx;
	logic [CoordW-1:0] worst_row_nx;
	logic [CountW-1:0] count_nx;
	logic [WidthW-1:0] width_eff;
	logic              row_end;

	// A result needs a free output register; other pixels never wait.
	assign pop = q_valid && (!q_item.last || !out_valid_q || out_ready);

	always_comb begin
		worst_nx     = worst_q;
		worst_col_nx = worst_col_q;
		worst_row_nx = worst_row_q;
		if (q_item.delta > worst_q) begin
			worst_nx     = q_item.delta;
			worst_col_nx = col_q;
			worst_row_nx = row_q;
		end
		count_nx = count_q;
		if (q_item.over && count_q != CountMax) begin
			count_nx = count_q + 1'b1;
		end
	end

	always_comb begin
		if (cfg.image_width == '0) begin
			width_eff = WidthOne;
		end else if (cfg.image_width > WidthMax) begin
			width_eff = WidthMax;
		end else begin
			width_eff = cfg.image_width;
		end
		row_end = ({1'b0, col_q} + WidthOne) >= width_eff;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q       <= '0;
			row_q       <= '0;
			worst_q     <= '0;
			worst_col_q <= '0;
			worst_row_q <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop && q_item.last) begin
				col_q       <= '0;
				row_q       <= '0;
				worst_q     <= '0;
				worst_col_q <= '0;
				worst_row_q <= '0;
				count_q     <= '0;
			end else if (pop) begin
				worst_q     <= worst_nx;
				worst_col_q <= worst_col_nx;
				worst_row_q <= worst_row_nx;
				count_q     <= count_nx;
				if (row_end) begin
					col_q <= '0;
					row_q <= row_q + 1'b1;
				end else begin
					col_q <= col_q + 1'b1;
				end
			end
			if (pop && q_item.last) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && q_item.last) begin
			out_q.worst_delta     <= worst_nx;
			out_q.worst_col       <= worst_col_nx;
			out_q.worst_row       <= worst_row_nx;
			out_q.differing_total <= count_nx;
			out_q.verdict         <= ({1'b0, worst_nx} < cfg.fatal_threshold) &&
				(count_nx <= cfg.allowed_count);
		end
	end

	assign out_valid  = out_valid_q;
	assign out_result = out_q;

	a_last_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		pop && q_item.last |=> out_valid_q && count_q == '0 && worst_q == '0)
		else $error("image end did not raise a result and clear the state");

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_ready && !(pop && q_item.last) |=> $stable(out_q))
		else $error("waiting result changed before it was taken");

endmodule
`default_nettype wire
